[hw/rtl/prime_factor_count_macros.svh]
// assertion macros for prime_factor_count
`ifndef PRIME_FACTOR_COUNT_MACROS_SVH
`define PRIME_FACTOR_COUNT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PFC_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("prime_factor_count assertion failed");

// next-cycle implication, disabled in reset
`define PFC_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("prime_factor_count assertion failed");

`endif

[hw/rtl/pfc_pkg.sv]
package pfc_pkg;

   localparam int COUNT_BITS = 5;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } pfc_div_status_type;

endpackage

[hw/rtl/pfc_divider.sv]
module pfc_divider import pfc_pkg::*; #(
   parameter int VALUE_BITS = 21,
   parameter int DIV_BITS   = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0]   divisor,
   output pfc_div_status_type    status,
   output logic [VALUE_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0]   div_ff, div_in;
   logic [DIV_BITS:0]     trial;
   logic [DIV_BITS:0]     diff;
   logic                  fits;

   // one restoring step per cycle
   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign fits  = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(VALUE_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);
   assign quotient        = quo_ff;

endmodule

[hw/rtl/prime_factor_count.sv]
// prime factor count (big omega) by trial division over a 2-3 wheel of candidates
// each trial is one pass of the shared radix-2 divider
// trials up to ~PRIME_LIMIT/3; one transaction at a time:
// the next is accepted once the count is in the output register
// reset is synchronous and clears control state only; candidates need no table or fill pass
module prime_factor_count import pfc_pkg::*; #(
   parameter int VALUE_BITS  = 21,
   parameter int PRIME_LIMIT = 1449
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COUNT_BITS-1:0] rsp_factor_count
);

`include "prime_factor_count_macros.svh"

   localparam int DIV_BITS = $clog2(PRIME_LIMIT + 4);
   localparam int CMP_BITS = (VALUE_BITS > DIV_BITS) ? VALUE_BITS : DIV_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic                  div_start_ff, div_start_in;
   logic                  step4_ff, step4_in;
   logic [DIV_BITS-1:0]   d_ff, d_in;
   logic [VALUE_BITS-1:0] rest_ff, rest_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   pfc_div_status_type    div_status;
   logic [VALUE_BITS-1:0] quotient;
   logic [DIV_BITS-1:0]   d_next;
   logic                  below_d;

   pfc_divider #(
      .VALUE_BITS(VALUE_BITS),
      .DIV_BITS  (DIV_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start_ff),
      .dividend(rest_ff),
      .divisor (d_ff),
      .status  (div_status),
      .quotient(quotient)
   );

   // candidates 2, 3, 5, then steps of +2 and +4
   always_comb begin
      if (d_ff == DIV_BITS'(2)) begin
         d_next = DIV_BITS'(3);
      end else if (d_ff == DIV_BITS'(3)) begin
         d_next = DIV_BITS'(5);
      end else begin
         d_next = d_ff + (step4_ff ? DIV_BITS'(4) : DIV_BITS'(2));
      end
   end

   // quotient below divisor means divisor squared exceeds the rest
   assign below_d = CMP_BITS'(quotient) < CMP_BITS'(d_ff);

   always_comb begin
      state_in     = state_ff;
      div_start_in = 1'b0;
      step4_in     = step4_ff;
      d_in         = d_ff;
      rest_in      = rest_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rest_in      = req_value;
               d_in         = DIV_BITS'(2);
               step4_in     = 1'b0;
               count_in     = '0;
               div_start_in = 1'b1;
               state_in     = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_status.done) begin
               if (below_d) begin
                  count_in = count_ff + COUNT_BITS'(rest_ff > VALUE_BITS'(1));
                  state_in = ST_OUT;
               end else if (div_status.rem_zero) begin
                  count_in     = count_ff + COUNT_BITS'(1);
                  rest_in      = quotient;
                  div_start_in = 1'b1;
               end else begin
                  d_in = d_next;
                  if (d_ff > DIV_BITS'(3)) begin
                     step4_in = !step4_ff;
                  end
                  if (d_next < DIV_BITS'(PRIME_LIMIT)) begin
                     div_start_in = 1'b1;
                  end else begin
                     count_in = count_ff + COUNT_BITS'(rest_ff > VALUE_BITS'(1));
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step4_ff     <= step4_in;
      d_ff         <= d_in;
      rest_ff      <= rest_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_factor_count = rsp_count_ff;

   `PFC_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, div_start_ff && state_ff == ST_WAIT)
   `PFC_ASSERT_SAME(a_done_in_wait, div_status.done, state_ff == ST_WAIT)
   `PFC_ASSERT_SAME(a_trial_in_range, div_start_ff, d_ff < DIV_BITS'(PRIME_LIMIT))
   `PFC_ASSERT_SAME(a_count_bound, rsp_valid, rsp_factor_count <= COUNT_BITS'(VALUE_BITS))

endmodule

[bench/prime_factor_count_tb.sv]
module prime_factor_count_tb;
   import pfc_pkg::*;

   localparam int VALUE_BITS = 21;
   localparam int PRIME_LIMIT = 1449;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
   localparam int HOLD_CYCLES = 3000;
   localparam int DRAIN_CYCLES = 256;
   localparam int ITEM_CYCLES_MAX = (PRIME_LIMIT / 2 + 2 * VALUE_BITS) * (VALUE_BITS + 2) + 64;
   localparam int CYCLE_LIMIT = 3 * (500 * (ITEM_CYCLES_MAX + 120) + 4 * HOLD_CYCLES);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COUNT_BITS-1:0] rsp_factor_count;

   int unsigned           prime_list[$];
   bit                    composite[PRIME_LIMIT];
   logic [COUNT_BITS-1:0] pending_counts[$];
   int                    failures = 0;
   int                    cycle_count = 0;
   bit                    quiet_mode = 1'b0;
   int                    hold_seq = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;
   int                    run_left = 0;

   prime_factor_count #(
      .VALUE_BITS (VALUE_BITS),
      .PRIME_LIMIT(PRIME_LIMIT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_factor_count(rsp_factor_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void sieve_primes();
      int unsigned i;
      int unsigned j;
      prime_list.delete();
      for (i = 0; i < PRIME_LIMIT; i++) composite[i] = 1'b0;
      for (i = 2; i < PRIME_LIMIT; i++) begin
         if (!composite[i]) begin
            prime_list = {prime_list, i};
            for (j = i * i; j < PRIME_LIMIT; j += i) composite[j] = 1'b1;
         end
      end
   endfunction

   // trial division over the sieved primes, leftover above one is one more factor
   function automatic logic [COUNT_BITS-1:0] count_prime_factors(logic [VALUE_BITS-1:0] value);
      longint unsigned rest;
      longint unsigned p;
      int unsigned     total;
      int              k;
      rest = value;
      total = 0;
      for (k = 0; k < prime_list.size(); k++) begin
         p = prime_list[k];
         if (p * p > rest) break;
         while (rest % p == 0) begin
            total++;
            rest = rest / p;
         end
      end
      if (rest > 1) total++;
      return total[COUNT_BITS-1:0];
   endfunction

   function automatic int pick_idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // mostly narrow values, some smooth products and products of two primes, a few full width ones
   function automatic logic [VALUE_BITS-1:0] pick_value();
      int              r;
      int              w;
      int              n;
      longint unsigned acc;
      longint unsigned p;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         w = $urandom_range(1, 14);
         return VALUE_BITS'($urandom & ((32'd1 << w) - 1));
      end
      if (r < 78) begin
         acc = 1;
         n = $urandom_range(1, 22);
         repeat (n) begin
            p = prime_list[$urandom_range(0, 5)];
            if (acc * p <= VALUE_MAX) acc = acc * p;
         end
         return VALUE_BITS'(acc);
      end
      if (r < 86) begin
         acc = prime_list[$urandom_range(0, prime_list.size() - 1)];
         acc = acc * prime_list[$urandom_range(0, prime_list.size() - 1)];
         return VALUE_BITS'(acc);
      end
      if (r < 93) begin
         w = $urandom_range(15, VALUE_BITS);
         return VALUE_BITS'($urandom & ((32'd1 << w) - 1));
      end
      return VALUE_BITS'($urandom);
   endfunction

   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      int gap;
      gap = quiet_mode ? 0 : pick_idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_value <= VALUE_BITS'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      pending_counts = {pending_counts, count_prime_factors(value)};
   endtask

   // receiver stall, with a long hold when the test asks for one
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (quiet_mode) begin
         rsp_stall <= 1'b0;
         run_left <= 0;
      end else if (run_left > 0) begin
         run_left <= run_left - 1;
      end else begin
         int stall_len;
         stall_len = pick_idle_length();
         if (stall_len == 0) begin
            rsp_stall <= 1'b0;
            run_left <= $urandom_range(0, 15);
         end else begin
            rsp_stall <= 1'b1;
            run_left <= stall_len - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_counts.size() == 0) begin
            $error("factor_count with no transaction pending: actual %0d", rsp_factor_count);
            failures++;
         end else begin
            logic [COUNT_BITS-1:0] want;
            want = pending_counts.pop_front();
            if (rsp_factor_count !== want) begin
               $error("factor_count mismatch: expected %0d, actual %0d", want, rsp_factor_count);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("prime_factor_count regression: fail");
         $finish;
      end
   end

   task automatic test_edge_values();
      logic [VALUE_BITS-1:0] values[$];
      values = {21'd0, 21'd1, 21'd2, 21'd3, 21'd4, VALUE_MAX, 21'd1048576, 21'd1572864,
                21'd1594323, 21'h155555, 21'h0aaaaa, 21'd2097143, 21'd2093809, 21'd2082233,
                21'd2087989, 21'd1447, 21'd1449, 21'd510510, 21'd1048575};
      foreach (values[i]) send_value(values[i]);
   endtask

   task automatic test_random_values(input int count);
      repeat (count) send_value(pick_value());
   endtask

   task automatic test_back_to_back(input int count);
      quiet_mode <= 1'b1;
      @(posedge clock);
      repeat (count) send_value(pick_value());
      quiet_mode <= 1'b0;
   endtask

   // receiver holds off while small values keep coming, so the input stalls
   task automatic test_output_hold(input int count);
      @(posedge clock);
      hold_seq <= hold_seq + 1;
      quiet_mode <= 1'b1;
      @(posedge clock);
      repeat (count) send_value(VALUE_BITS'($urandom_range(0, 255)));
      quiet_mode <= 1'b0;
   endtask

   initial begin
      sieve_primes();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_values();
      test_random_values(395);
      test_back_to_back(20);
      test_output_hold(16);
      req_valid <= 1'b0;
      while (pending_counts.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("prime_factor_count regression: pass");
      end else begin
         $display("prime_factor_count regression: fail");
      end
      $finish;
   end

endmodule
